// ===== hdl/rgs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgs_pkg
// Shared sizes, register indexes and sequencer states of the gain stepper.
// ----------------------------------------------------------------------------
package rgs_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int CHANNELS    = 2;

  localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ENTRY_W = 24;

  localparam int SEARCH_MARGIN_DB = 8;

  localparam logic [2:0] CFG_TARGET_RSSI   = 3'd0;
  localparam logic [2:0] CFG_ATTACK_THRESH = 3'd1;
  localparam logic [2:0] CFG_HYSTERESIS    = 3'd2;
  localparam logic [2:0] CFG_HOLD_FAST     = 3'd3;
  localparam logic [2:0] CFG_HOLD_SLOW     = 3'd4;
  localparam logic [2:0] CFG_HOLD_DEFAULT  = 3'd5;
  localparam logic [2:0] CFG_ENTRIES       = 3'd6;

  localparam logic [1:0] CLASS_FAST = 2'd0;
  localparam logic [1:0] CLASS_SLOW = 2'd1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EVAL,
    ST_ATTACK,
    ST_SEARCH,
    ST_CUT,
    ST_RELEASE,
    ST_FETCH,
    ST_G0,
    ST_GCUR,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/rgs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgs_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/rssi_gain_stepper_agc_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rssi_gain_stepper_agc_unit
// Two-channel receiver gain stepper: fast attack, hold, slow release.
//
// Input beats arrive on item_valid / item_stall. A load beat (cmd = 1)
// writes one gain table entry. A control tick (cmd = 0) updates the gain
// index of channel vfo and gives a result beat on result_valid /
// result_stall, carrying the register word when the index has moved.
// Every input beat gives exactly one result beat.
// A load or an ignored tick goes from decode straight to the result; a
// frequency change fetches the gains first; a tick evaluates, attacks and
// releases first, an overshoot also cuts, and a large one runs a downward search
// (up to TABLE_DEPTH - 2 entries), which reads the gain table RAM one entry a cycle.
// item_stall is high from acceptance until the result sits in the output
// register; a new beat is taken while that result still waits.
// While result_stall is high the result holds and the next tick's result
// waits in the sequencer.
// Reset clears channel state and restores register defaults; table
// contents are undefined until loaded. Registers are written on the
// cfg_write port, by the user only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module rssi_gain_stepper_agc_unit
  import rgs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               cmd,
  input  logic               vfo,
  input  logic               active,
  input  logic [31:0]        frequency,
  input  logic [8:0]         rssi,
  input  logic [1:0]         signal_class,
  input  logic [6:0]         entry_index,
  input  logic signed [7:0]  entry_gain_db,
  input  logic [15:0]        entry_reg_val,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               write_valid,
  output logic [15:0]        reg_value,
  output logic [6:0]         gain_index,
  output logic signed [8:0]  gain_diff_db,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  state_t state, state_next;

  logic [8:0] target_rssi;
  logic [5:0] attack_threshold_db;
  logic [5:0] hysteresis_db;
  logic [7:0] hold_fast;
  logic [7:0] hold_slow;
  logic [7:0] hold_default;
  logic [7:0] entries_in_use;

  logic [31:0]      last_freq     [CHANNELS];
  logic [IDX_W-1:0] cur_index     [CHANNELS];
  logic [IDX_W-1:0] written_index [CHANNELS];
  logic [8:0]       last_rssi     [CHANNELS];
  logic [7:0]       hold_count    [CHANNELS];

  logic              cmd_q;
  logic              vfo_q;
  logic              active_q;
  logic [31:0]       freq_q;
  logic [8:0]        rssi_q;
  logic [1:0]        class_q;
  logic [6:0]        eidx_q;
  logic [7:0]        egain_q;
  logic [15:0]       eword_q;

  logic [CH_W-1:0]   ch;
  logic              ch_ok;

  logic signed [9:0]  diff_q;
  logic signed [10:0] want_q;
  logic [IDX_W-1:0]   cur_w;
  logic [IDX_W-1:0]   idx_w;
  logic [7:0]         hold_w;
  logic               force_q;
  logic signed [7:0]  g0_q;

  logic               res_wv;
  logic [15:0]        res_word;
  logic [IDX_W-1:0]   res_idx;
  logic signed [8:0]  res_diff;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [IDX_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic signed [7:0]   rd_gain;
  logic [15:0]         rd_word;

  logic [9:0]          rssi_sum;
  logic [8:0]          avg;
  logic signed [10:0]  err;
  logic signed [10:0]  err_r;
  logic signed [10:0]  half;
  logic signed [9:0]   neg_hyst;
  logic                diff_pos;
  logic                big_cut;
  logic                found;
  logic                hold_reload;
  logic [7:0]          hold_eff;
  logic [7:0]          hold_cut;
  logic [IDX_W-1:0]    top_idx;
  logic [IDX_W:0]      up_idx;
  logic [IDX_W-1:0]    rel_idx;
  logic                load_ok;
  logic                out_free;

  assign ch       = CH_W'(vfo_q);
  assign ch_ok    = (32'(vfo_q) < 32'(CHANNELS));
  assign rd_gain  = ram_rdata[23:16];
  assign rd_word  = ram_rdata[15:0];
  assign load_ok  = (32'(eidx_q) < 32'(TABLE_DEPTH));
  assign out_free = !result_valid || !result_stall;

  assign rssi_sum = {1'b0, last_rssi[ch]} + {1'b0, rssi_q};
  assign avg      = (last_rssi[ch] != 9'd0) ? rssi_sum[9:1] : rssi_q;
  assign err      = $signed({2'b00, avg}) - $signed({2'b00, target_rssi});
  assign err_r    = err + $signed({10'd0, err[10]});
  assign half     = err_r >>> 1;

  assign neg_hyst    = -$signed({4'd0, hysteresis_db});
  assign diff_pos    = (diff_q > 10'sd0);
  assign big_cut     = (diff_q >= $signed({4'd0, attack_threshold_db}));
  assign found       = ($signed({{3{rd_gain[7]}}, rd_gain}) <= want_q);
  assign hold_reload = (diff_q >= neg_hyst);
  assign hold_eff    = hold_reload ? hold_default : hold_w;

  always_comb begin
    case (class_q)
      CLASS_FAST: hold_cut = hold_fast;
      CLASS_SLOW: hold_cut = hold_slow;
      default:    hold_cut = hold_default;
    endcase
  end

  always_comb begin
    if (entries_in_use < 8'd2) begin
      top_idx = IDX_W'(1);
    end else if (32'(entries_in_use) > 32'(TABLE_DEPTH)) begin
      top_idx = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      top_idx = IDX_W'(entries_in_use - 8'd1);
    end
  end

  assign up_idx  = {1'b0, cur_w} + {{IDX_W{1'b0}}, 1'b1};
  assign rel_idx = (up_idx > {1'b0, top_idx}) ? top_idx : up_idx[IDX_W-1:0];

  rgs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({egain_q, eword_q}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_waddr = IDX_W'(eidx_q);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        if (cmd_q || !active_q || !ch_ok) state_next = ST_DONE;
        else if (freq_q != last_freq[ch]) state_next = ST_FETCH;
        else state_next = ST_EVAL;
      end
      ST_EVAL:    state_next = ST_ATTACK;
      ST_ATTACK: begin
        if (!diff_pos) state_next = ST_RELEASE;
        else if (big_cut && cur_w > IDX_W'(1)) state_next = ST_SEARCH;
        else state_next = ST_CUT;
      end
      ST_SEARCH: begin
        if (found || idx_w == IDX_W'(1)) state_next = ST_CUT;
      end
      ST_CUT:     state_next = ST_RELEASE;
      ST_RELEASE: state_next = ST_FETCH;
      ST_FETCH:   state_next = ST_G0;
      ST_G0:      state_next = ST_GCUR;
      ST_GCUR:    state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    item_stall = 1'b1;
    ram_we     = 1'b0;
    ram_raddr  = '0;
    case (state)
      ST_IDLE:   item_stall = 1'b0;
      ST_DECODE: ram_we     = cmd_q && load_ok;
      ST_EVAL:   ram_raddr  = cur_index[ch];
      ST_ATTACK: ram_raddr  = cur_w - IDX_W'(1);
      ST_SEARCH: ram_raddr  = idx_w - IDX_W'(1);
      ST_G0:     ram_raddr  = cur_w;
      default:   ram_raddr  = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_rssi         <= 9'd170;
      attack_threshold_db <= 6'd10;
      hysteresis_db       <= 6'd6;
      hold_fast           <= 8'd15;
      hold_slow           <= 8'd50;
      hold_default        <= 8'd30;
      entries_in_use      <= 8'd128;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TARGET_RSSI:   target_rssi         <= cfg_data;
        CFG_ATTACK_THRESH: attack_threshold_db <= cfg_data[5:0];
        CFG_HYSTERESIS:    hysteresis_db       <= cfg_data[5:0];
        CFG_HOLD_FAST:     hold_fast           <= cfg_data[7:0];
        CFG_HOLD_SLOW:     hold_slow           <= cfg_data[7:0];
        CFG_HOLD_DEFAULT:  hold_default        <= cfg_data[7:0];
        CFG_ENTRIES:       entries_in_use      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) begin
      cmd_q    <= cmd;
      vfo_q    <= vfo;
      active_q <= active;
      freq_q   <= frequency;
      rssi_q   <= rssi;
      class_q  <= signal_class;
      eidx_q   <= entry_index;
      egain_q  <= entry_gain_db;
      eword_q  <= entry_reg_val;
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        last_freq[i]     <= '0;
        cur_index[i]     <= '0;
        written_index[i] <= '0;
        last_rssi[i]     <= '0;
        hold_count[i]    <= '0;
      end
    end else begin
      case (state)
        ST_DECODE: begin
          if (!cmd_q && active_q && ch_ok && freq_q != last_freq[ch]) begin
            last_freq[ch]     <= freq_q;
            cur_index[ch]     <= '0;
            written_index[ch] <= '0;
            last_rssi[ch]     <= '0;
            hold_count[ch]    <= '0;
          end
        end
        ST_EVAL:    last_rssi[ch] <= rssi_q;
        ST_RELEASE: begin
          hold_count[ch] <= hold_eff;
          cur_index[ch]  <= (hold_eff == 8'd0) ? rel_idx : cur_w;
        end
        ST_GCUR:    written_index[ch] <= cur_w;
        default: ;
      endcase
    end
  end

  // working registers and pending result
  always_ff @(posedge clk) begin
    case (state)
      ST_DECODE: begin
        force_q  <= 1'b1;
        cur_w    <= '0;
        res_wv   <= 1'b0;
        res_word <= '0;
        res_diff <= '0;
        res_idx  <= (!cmd_q && ch_ok) ? cur_index[ch] : '0;
      end
      ST_EVAL: begin
        force_q <= 1'b0;
        diff_q  <= half[9:0];
        cur_w   <= cur_index[ch];
        hold_w  <= (hold_count[ch] != 8'd0) ? hold_count[ch] - 8'd1 : 8'd0;
      end
      ST_ATTACK: begin
        want_q <= $signed({{3{rd_gain[7]}}, rd_gain}) - $signed({diff_q[9], diff_q})
                  + 11'(SEARCH_MARGIN_DB);
        idx_w  <= (cur_w > IDX_W'(1)) ? cur_w - IDX_W'(1) : IDX_W'(1);
      end
      ST_SEARCH: begin
        if (!(found || idx_w == IDX_W'(1))) idx_w <= idx_w - IDX_W'(1);
      end
      ST_CUT: begin
        if (idx_w != cur_w) begin
          cur_w  <= idx_w;
          hold_w <= hold_cut;
        end
      end
      ST_RELEASE: begin
        if (hold_eff == 8'd0) cur_w <= rel_idx;
      end
      ST_G0:      g0_q <= rd_gain;
      ST_GCUR: begin
        res_wv   <= force_q || (cur_w != written_index[ch]);
        res_word <= (force_q || (cur_w != written_index[ch])) ? rd_word : 16'd0;
        res_idx  <= cur_w;
        res_diff <= $signed({g0_q[7], g0_q}) - $signed({rd_gain[7], rd_gain});
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      write_valid  <= res_wv;
      reg_value    <= res_word;
      gain_index   <= 7'(res_idx);
      gain_diff_db <= res_diff;
    end
  end

endmodule

// ===== hdl/rgs_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgs_chk
// Port-level checks on the gain stepper, bound to the top level.
// ----------------------------------------------------------------------------
module rgs_chk (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic               write_valid,
  input logic [15:0]        reg_value,
  input logic [6:0]         gain_index,
  input logic signed [8:0]  gain_diff_db
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result beat shown straight after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("input taken twice in successive cycles");

  a_no_word_without_write: assert property (@(posedge clk) disable iff (rst)
    result_valid && !write_valid |-> reg_value == 16'd0)
    else $error("register word present on a beat with no write");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(reg_value) && $stable(gain_index)
      && $stable(gain_diff_db) && $stable(write_valid))
    else $error("stalled result beat changed");

endmodule

bind rssi_gain_stepper_agc_unit rgs_chk u_rgs_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .write_valid  (write_valid),
  .reg_value    (reg_value),
  .gain_index   (gain_index),
  .gain_diff_db (gain_diff_db)
);
